[design/arpc_pkg.sv]
// Shared types and constants for the ARP cache next-hop resolver.
// Used by every design file; depends on nothing.

package arpc_pkg;

    // Table geometry. Both widths follow from the entry count.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 4;

    // Register file on the APB port.
    localparam int NUM_REGS = 3;
    localparam int PADDR_W  = $clog2(NUM_REGS) + 2;
    localparam int RIDX_W   = PADDR_W - 2;

    localparam logic [RIDX_W-1:0] REG_LOCAL_IP    = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] REG_SUBNET_MASK = RIDX_W'(1);
    localparam logic [RIDX_W-1:0] REG_GATEWAY_IP  = RIDX_W'(2);

    // Operation codes on the input channel.
    localparam logic OP_LEARN   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    localparam logic [7:0]       BCAST_OCTET = 8'hFF;
    localparam logic [MAC_W-1:0] BCAST_MAC   = {6{BCAST_OCTET}};

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } arpc_entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        arpc_entry_t       data;
    } arpc_wr_t;

    typedef struct packed {
        logic [IP_W-1:0] local_ip;
        logic [IP_W-1:0] subnet_mask;
        logic [IP_W-1:0] gateway_ip;
    } arpc_cfg_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   next_hop_ip;
        logic [MAC_W-1:0]  dest_mac;
        logic              send_request;
    } arpc_result_t;

endpackage

[design/arp_cache_next_hop_resolver.sv]
// Top level of the ARP cache next-hop resolver: APB register file, result
// register, lookup sequencer and binding table. Depends on arpc_pkg,
// arpc_table_ram and arpc_engine.
//
// Usage:
//   Input channel (s_*): op 0 learns the binding addr_ip -> hw_addr, op 1
//   resolves addr_ip. A resolve outside the subnet set by local_ip and
//   subnet_mask looks up gateway_ip instead. One result per transaction
//   on the m_* channel.
//   Registers on APB: local_ip at 0x0, subnet_mask at 0x4, gateway_ip at 0x8.
//   Write them only while no transaction is in flight.
// Timing:
//   The filled entries are scanned one per cycle through the single read
//   port of the table RAM, whose read data is registered. A transaction
//   that matches an entry ends the scan there; a miss scans every filled
//   entry, and a transaction on an empty table skips the scan. The next
//   transaction is taken in the cycle after the handoff. One transaction
//   is in work at a time.
// Reset:
//   aresetn clears the registers and the fill count; the table holds no
//   bindings after reset. No clearing pass is needed.
// Backpressure:
//   A finished result waits in the output register while the next
//   transaction is scanned; the engine holds its result if that register
//   is still occupied.

module arp_cache_next_hop_resolver import arpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [IP_W-1:0]    s_addr_ip,
    input  logic [MAC_W-1:0]   s_hw_addr,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [SLOT_W-1:0]  m_slot,
    output logic [IP_W-1:0]    m_next_hop_ip,
    output logic [MAC_W-1:0]   m_dest_mac,
    output logic               m_send_request
);

    arpc_cfg_t    cfg_reg;
    logic         m_valid_reg;
    arpc_result_t m_res_reg;

    logic             res_valid;
    logic             res_ready;
    arpc_result_t     res;
    logic [IDX_W-1:0] rd_addr;
    arpc_entry_t      rd_data;
    arpc_wr_t         wr;
    logic [RIDX_W-1:0] reg_idx;
    logic             reg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_LOCAL_IP:    cfg_reg.local_ip    <= pwdata;
                REG_SUBNET_MASK: cfg_reg.subnet_mask <= pwdata;
                REG_GATEWAY_IP:  cfg_reg.gateway_ip  <= pwdata;
                default: begin
                    // drop writes beyond the register file
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOCAL_IP:    prdata = cfg_reg.local_ip;
            REG_SUBNET_MASK: prdata = cfg_reg.subnet_mask;
            REG_GATEWAY_IP:  prdata = cfg_reg.gateway_ip;
            default:         prdata = '0;
        endcase
    end

    arpc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_op     (s_op),
        .in_ip     (s_addr_ip),
        .in_mac    (s_hw_addr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr        (wr)
    );

    arpc_table_ram u_table (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // Output register: load when empty or being drained this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_res_reg.hit;
    assign m_slot         = m_res_reg.slot;
    assign m_next_hop_ip  = m_res_reg.next_hop_ip;
    assign m_dest_mac     = m_res_reg.dest_mac;
    assign m_send_request = m_res_reg.send_request;

    // A new transaction closes the input until its result has been handed on.
    a_single_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a lookup is in progress");

    // A request for ARP always goes with the broadcast address and no binding.
    a_miss_format: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_send_request) |->
            (!m_hit && m_slot == '0 && m_dest_mac == BCAST_MAC))
        else $error("malformed miss result");

    // The output register fills only from a finished lookup.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(res_valid))
        else $error("result appeared without a finished lookup");

    // The table is only written as a lookup hands on its result.
    a_write_at_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (res_valid && res_ready))
        else $error("table written outside result handoff");

endmodule

[design/arpc_table_ram.sv]
// Binding table: one write port, one read port, registered read data.
// Depends on arpc_pkg for the entry type and the table depth.

module arpc_table_ram import arpc_pkg::*; (
    input  logic             aclk,
    input  logic [IDX_W-1:0] rd_addr,
    output arpc_entry_t      rd_data,
    input  arpc_wr_t         wr
);

    arpc_entry_t mem [ENTRIES];
    arpc_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/arpc_engine.sv]
// Lookup sequencer: picks the next hop, scans the filled entries one per
// cycle through the table RAM, then writes back learned bindings.
// Depends on arpc_pkg.

module arpc_engine import arpc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  arpc_cfg_t        cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic [IP_W-1:0]  in_ip,
    input  logic [MAC_W-1:0] in_mac,
    output logic             res_valid,
    input  logic             res_ready,
    output arpc_result_t     res,
    output logic [IDX_W-1:0] rd_addr,
    input  arpc_entry_t      rd_data,
    output arpc_wr_t         wr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic             op_reg, op_next;
    logic [IP_W-1:0]  key_reg, key_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic             off_subnet;
    logic [IP_W-1:0]  hop;
    logic             match;
    logic             last_cmp;
    logic             room;
    logic [IDX_W-1:0] new_idx;
    logic [IDX_W-1:0] learn_idx;

    assign off_subnet = (in_ip & cfg.subnet_mask) != (cfg.local_ip & cfg.subnet_mask);
    assign hop        = (in_op == OP_RESOLVE && off_subnet) ? cfg.gateway_ip : in_ip;
    assign match      = cmp_vld_reg && (rd_data.ip == key_reg);
    assign last_cmp   = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == fill_reg;
    assign room       = fill_reg < CNT_W'(ENTRIES);
    // A full table recycles entry 0.
    assign new_idx    = room ? fill_reg[IDX_W-1:0] : '0;
    assign learn_idx  = found_reg ? found_idx_reg : new_idx;

    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_FINISH);
    assign rd_addr    = issue_reg[IDX_W-1:0];

    always_comb begin
        res.next_hop_ip = key_reg;
        res.hit         = found_reg;
        if (op_reg == OP_LEARN) begin
            res.slot         = SLOT_W'(learn_idx);
            res.dest_mac     = mac_reg;
            res.send_request = 1'b0;
        end else begin
            res.slot         = found_reg ? SLOT_W'(found_idx_reg) : '0;
            res.dest_mac     = found_reg ? mac_reg : BCAST_MAC;
            res.send_request = !found_reg;
        end
    end

    always_comb begin
        wr.en        = (state_reg == ST_FINISH) && res_ready && (op_reg == OP_LEARN);
        wr.addr      = learn_idx;
        wr.data.ip   = key_reg;
        wr.data.mac  = mac_reg;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        mac_next       = mac_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        fill_next      = fill_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = in_op;
                    key_next   = hop;
                    mac_next   = in_mac;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = (fill_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle; compare each read's data when the RAM returns it.
                if (issue_reg < fill_reg) begin
                    issue_next   = issue_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                end
                if (match) begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                    if (op_reg == OP_RESOLVE) begin
                        mac_next = rd_data.mac;
                    end
                    cmp_vld_next = 1'b0;
                    state_next   = ST_FINISH;
                end else if (cmp_vld_reg && last_cmp) begin
                    cmp_vld_next = 1'b0;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    if (op_reg == OP_LEARN && !found_reg && room) begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            fill_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            fill_reg    <= fill_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        mac_reg       <= mac_next;
        issue_reg     <= issue_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
    end

endmodule

[verif/tb_arp_cache_next_hop_resolver.sv]
// Self-checking testbench for arp_cache_next_hop_resolver: a queue-fed driver,
// a monitor that predicts each result from a private copy of the binding table,
// and APB register writes between phases. Depends on arpc_pkg and the design.
`timescale 1ns / 100ps

module tb_arp_cache_next_hop_resolver;
    import arpc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 432;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = ENTRIES + 8;

    // Address 0xC decodes to no register; writes there must be dropped.
    localparam logic [RIDX_W-1:0] REG_SPARE = RIDX_W'(3);

    typedef struct {
        logic             op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } arp_req_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic               s_op      = OP_LEARN;
    logic [IP_W-1:0]    s_addr_ip = '0;
    logic [MAC_W-1:0]   s_hw_addr = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_hit;
    logic [SLOT_W-1:0]  m_slot;
    logic [IP_W-1:0]    m_next_hop_ip;
    logic [MAC_W-1:0]   m_dest_mac;
    logic               m_send_request;

    arp_cache_next_hop_resolver u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_addr_ip      (s_addr_ip),
        .s_hw_addr      (s_hw_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_slot         (m_slot),
        .m_next_hop_ip  (m_next_hop_ip),
        .m_dest_mac     (m_dest_mac),
        .m_send_request (m_send_request)
    );

    always #10 aclk = ~aclk;

    // Private copy of the table and registers.
    logic [IP_W-1:0]  tbl_ip    [ENTRIES];
    logic [MAC_W-1:0] tbl_mac   [ENTRIES];
    bit               tbl_valid [ENTRIES];
    int               tbl_fill;
    logic [IP_W-1:0]  cfg_local;
    logic [IP_W-1:0]  cfg_mask;
    logic [IP_W-1:0]  cfg_gateway;

    arp_req_t     req_backlog[$];
    arpc_result_t lookups_due[$];
    arp_req_t     drv_item;
    arpc_result_t want;

    int  items_queued = 0;
    int  items_taken  = 0;
    int  errors       = 0;
    int  cycle_count  = 0;
    int  n_learn      = 0;
    int  n_resolve    = 0;
    int  n_hit        = 0;
    int  n_request    = 0;
    int  n_settings   = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_token   = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;
    bit  in_taken     = 1'b0;

    logic [IP_W-1:0] known_ip [15];

    // Update the table copy for one transaction and return the result it owes.
    function automatic arpc_result_t cache_lookup(logic op, logic [IP_W-1:0] ip,
                                                  logic [MAC_W-1:0] mac);
        arpc_result_t    r;
        logic [IP_W-1:0] hop;
        bit              found;
        int              i;
        r     = '0;
        found = 1'b0;
        if (op == OP_LEARN) begin
            r.next_hop_ip = ip;
            r.dest_mac    = mac;
            for (i = 0; i < tbl_fill && !found; i++) begin
                if (tbl_ip[i] == ip) begin
                    tbl_mac[i]   = mac;
                    tbl_valid[i] = 1'b1;
                    r.hit        = 1'b1;
                    r.slot       = SLOT_W'(i);
                    found        = 1'b1;
                end
            end
            if (!found) begin
                // Append while there is room, else overwrite entry 0.
                i = (tbl_fill < ENTRIES) ? tbl_fill : 0;
                tbl_ip[i]    = ip;
                tbl_mac[i]   = mac;
                tbl_valid[i] = 1'b1;
                r.slot       = SLOT_W'(i);
                if (tbl_fill < ENTRIES)
                    tbl_fill++;
            end
        end else begin
            hop = ((ip & cfg_mask) != (cfg_local & cfg_mask)) ? cfg_gateway : ip;
            r.next_hop_ip  = hop;
            r.dest_mac     = BCAST_MAC;
            r.send_request = 1'b1;
            for (i = 0; i < tbl_fill && !found; i++) begin
                if (tbl_valid[i] && tbl_ip[i] == hop) begin
                    r.hit          = 1'b1;
                    r.slot         = SLOT_W'(i);
                    r.dest_mac     = tbl_mac[i];
                    r.send_request = 1'b0;
                    found          = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic push_req(logic op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        arp_req_t t;
        t.op  = op;
        t.ip  = ip;
        t.mac = mac;
        req_backlog.push_back(t);
        items_queued++;
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    task automatic apb_write(logic [RIDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_LOCAL_IP:    cfg_local   = val;
            REG_SUBNET_MASK: cfg_mask    = val;
            REG_GATEWAY_IP:  cfg_gateway = val;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (items_taken != items_queued || lookups_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_random_items(int count);
        logic [IP_W-1:0] ip;
        int              r;
        repeat (count) begin
            r = $urandom_range(99);
            if ($urandom_range(99) < 45) begin
                // Relearn a resident binding now and then, mostly new ones.
                ip = (r < 30) ? known_ip[$urandom_range(14)] : IP_W'($urandom());
                push_req(OP_LEARN, ip, rand_mac());
            end else begin
                if (r < 40)
                    ip = known_ip[$urandom_range(14)];
                else if (r < 60)
                    ip = (cfg_local & cfg_mask) | (IP_W'($urandom()) & ~cfg_mask);
                else if (r < 70)
                    ip = cfg_gateway;
                else
                    ip = IP_W'($urandom());
                push_req(OP_RESOLVE, ip, rand_mac());
            end
        end
    endtask

    // Driver: present the next transaction at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold until accepted
        end else if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_item  = req_backlog.pop_front();
            s_valid   <= 1'b1;
            s_op      <= drv_item.op;
            s_addr_ip <= drv_item.ip;
            s_hw_addr <= drv_item.mac;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random ready, with one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: check results against the oldest prediction, predict new ones.
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (lookups_due.size() == 0) begin
                    $error("result with nothing expected: next_hop_ip %0h", m_next_hop_ip);
                    errors++;
                end else begin
                    want = lookups_due.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0h, actual %0h", want.hit, m_hit);
                        errors++;
                    end
                    if (m_slot !== want.slot) begin
                        $error("slot: expected %0h, actual %0h", want.slot, m_slot);
                        errors++;
                    end
                    if (m_next_hop_ip !== want.next_hop_ip) begin
                        $error("next_hop_ip: expected %0h, actual %0h",
                               want.next_hop_ip, m_next_hop_ip);
                        errors++;
                    end
                    if (m_dest_mac !== want.dest_mac) begin
                        $error("dest_mac: expected %0h, actual %0h", want.dest_mac, m_dest_mac);
                        errors++;
                    end
                    if (m_send_request !== want.send_request) begin
                        $error("send_request: expected %0h, actual %0h",
                               want.send_request, m_send_request);
                        errors++;
                    end
                    if (want.hit)
                        n_hit++;
                    if (want.send_request)
                        n_request++;
                end
            end
            if (s_valid && s_ready) begin
                lookups_due.push_back(cache_lookup(s_op, s_addr_ip, s_hw_addr));
                items_taken++;
                if (s_op == OP_LEARN)
                    n_learn++;
                else
                    n_resolve++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < ENTRIES; k++) begin
            tbl_ip[k]    = '0;
            tbl_mac[k]   = '0;
            tbl_valid[k] = 1'b0;
        end
        tbl_fill    = 0;
        cfg_local   = '0;
        cfg_mask    = '0;
        cfg_gateway = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 49;

        // Registers are still zero: mask zero makes every destination local.
        push_req(OP_RESOLVE, '0, '0);                    // empty table, address 0 misses
        push_req(OP_LEARN, '0, '0);
        push_req(OP_LEARN, '1, '1);
        push_req(OP_LEARN, '0, 48'h0123_4567_89AB);      // same IP: update the MAC
        push_req(OP_RESOLVE, '0, '1);
        push_req(OP_RESOLVE, '1, '0);
        push_req(OP_RESOLVE, 32'h0A00_0001, rand_mac());
        known_ip[0] = '1;
        for (k = 1; k < 15; k++) begin
            known_ip[k] = IP_W'($urandom()) | 32'h0100_0000;
            push_req(OP_LEARN, known_ip[k], rand_mac());
        end
        // Table is full now: a new IP lands in entry 0.
        push_req(OP_LEARN, 32'hC0A8_0101, rand_mac());
        push_req(OP_RESOLVE, '0, rand_mac());
        push_req(OP_RESOLVE, 32'hC0A8_0101, rand_mac());
        drain();

        for (k = 0; k < 4; k++) begin
            drain();
            case (k)
                0: begin
                    apb_write(REG_LOCAL_IP, $urandom());
                    apb_write(REG_SUBNET_MASK, 32'hFFFF_FF00);
                    apb_write(REG_GATEWAY_IP, known_ip[$urandom_range(14)]);
                    apb_write(REG_SPARE, $urandom());
                end
                1: begin
                    apb_write(REG_LOCAL_IP, 32'hFFFF_FFFF);
                    apb_write(REG_SUBNET_MASK, 32'hFFFF_FFFF);
                    apb_write(REG_GATEWAY_IP, 32'h0000_0000);
                end
                2: begin
                    apb_write(REG_LOCAL_IP, 32'h0000_0000);
                    apb_write(REG_SUBNET_MASK, 32'h0000_0000);
                    apb_write(REG_GATEWAY_IP, 32'hFFFF_FFFF);
                    send_idle_pct = 49;
                    recv_idle_pct = 27;
                end
                default: begin
                    apb_write(REG_LOCAL_IP, $urandom());
                    apb_write(REG_SUBNET_MASK, 32'hFFFF_0000);
                    apb_write(REG_GATEWAY_IP, known_ip[$urandom_range(14)]);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // Starve the output so the block backs up into s_ready.
                    hold_token++;
                end
            endcase
            n_settings++;
            queue_random_items(PHASE_ITEMS);
        end

        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d learns and %0d resolves across %0d register settings",
                 n_learn, n_resolve, n_settings + 1);
        $display("  %0d lookups hit, %0d ended in an ARP request", n_hit, n_request);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
